/* sv/assert_macros.svh */
// Assertion macros for the checker file.
// No dependencies; included by bme_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle after ante, with reset disabling the check.
`define BME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bme check failed");

// Check that cons holds in the same cycle as ante, with reset disabling the check.
`define BME_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bme check failed");

`endif

/* sv/bme_pkg.sv */
// Shared types, constants and codes for the batch-means error estimator.
// No dependencies; compiled first.
package bme_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int SAMPLE_W      = 8;
   localparam int CSR_W         = 12;
   localparam int EFF_W         = CSR_W + 1;
   localparam int NUM_W         = 64;
   localparam int DEN_W         = 61;
   localparam int QUO_W         = 49;
   localparam int SHIFT_W       = $clog2(2 * FRACTION_BITS + 1);
   localparam int CNT_W         = $clog2(NUM_W + 2 * FRACTION_BITS + 1);
   localparam int ROOT_W        = 24;

   typedef enum logic [0:0] {
      CSR_BLOCK_SIZE  = 1'b0,
      CSR_BLOCK_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_BS, OP_TT, OP_QLO, OP_QHI, OP_BB1, OP_SS, OP_DEN,
      OP_D2LO, OP_D2HI, OP_NUM, OP_MEAN_START, OP_MEAN_STORE,
      OP_VAR_START, OP_VAR_STORE, OP_SE_START, OP_SE_STORE,
      OP_SQRT_START, OP_SQRT_STORE, OP_OUT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_BS, ST_TT, ST_QLO, ST_QHI, ST_BB1, ST_SS, ST_DEN,
      ST_D2LO, ST_D2HI, ST_NUM, ST_MEAN_GO, ST_MEAN_WAIT, ST_VAR_GO,
      ST_VAR_WAIT, ST_SE_GO, ST_SE_WAIT, ST_SQ_GO, ST_SQ_WAIT, ST_OUT
   } state_type;

   typedef struct packed {
      op_type op;
      logic   req_ready;
   } cmd_type;

   typedef struct packed {
      logic last_item;
      logic rsp_busy;
      logic div_done;
      logic sqrt_done;
      logic b_is_one;
   } status_type;

endpackage

/* sv/bme_if.sv */
// Word channel interfaces for the estimator: sample words in, statistics out.
// Depends on bme_pkg.
interface bme_req_if;
   import bme_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bme_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] run_total;
   logic [51:0] run_sum_squares;
   logic [23:0] mean_q16;
   logic [30:0] variance_q16;
   logic [23:0] std_error_q16;
   modport source (output valid, output run_total, output run_sum_squares,
                   output mean_q16, output variance_q16, output std_error_q16,
                   input ready);
   modport sink   (input valid, input run_total, input run_sum_squares,
                   input mean_q16, input variance_q16, input std_error_q16,
                   output ready);
endinterface

/* sv/batch_means_error_estimator_core.sv */
// Batch-means error estimator, top level. Takes one sample word per clock
// while a run is in progress: samples add into a block subtotal, each full
// block adds its subtotal to the run total and its square to the run sum of
// squares. The word that closes a run starts the statistics sequence, during
// which req_word.ready stays low: multiplies on one shared 32x32 multiplier,
// three serial divides and a serial square root (only the mean divide when
// block_count is one and the spread figures are zero), then a load of the
// output register. The result word then sits in the output register while
// sampling resumes; only a word that would close the next run waits for it
// to be taken. Configuration is written through csr_we/csr_index/csr_wdata,
// by the user only while idle; the block does not enforce it. A write
// reloads the matching countdown. Depends on bme_pkg, bme_if, bme_ctrl and
// bme_dpath.
module batch_means_error_estimator_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [bme_pkg::CSR_W-1:0] csr_wdata,
   bme_req_if.sink                   req_word,
   bme_rsp_if.source                 rsp_word
);
   import bme_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: owns input acceptance and the end-of-run sequence
   bme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_word.valid),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_word.ready = cmd.req_ready;

   // datapath: accumulate, snapshot, compute, hold the result word
   bme_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_word.valid),
      .req_sample          (req_word.sample),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp_word.ready),
      .rsp_valid           (rsp_word.valid),
      .rsp_run_total       (rsp_word.run_total),
      .rsp_run_sum_squares (rsp_word.run_sum_squares),
      .rsp_mean_q16        (rsp_word.mean_q16),
      .rsp_variance_q16    (rsp_word.variance_q16),
      .rsp_std_error_q16   (rsp_word.std_error_q16)
   );
endmodule

/* sv/bme_div.sv */
// Serial restoring divider, one quotient bit per cycle, with an overflow flag.
// Depends on bme_pkg.
module bme_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bme_pkg::NUM_W-1:0]    num,
   input  logic [bme_pkg::DEN_W-1:0]    den,
   input  logic [bme_pkg::SHIFT_W-1:0]  shift,
   output logic                         done,
   output logic [bme_pkg::QUO_W-1:0]    quo,
   output logic                         ovf
);
   import bme_pkg::*;

   logic             busy_ff, busy_in, done_ff, done_in, ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] dvd_ff, dvd_in;
   logic [DEN_W-1:0] den_ff, den_in, rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      trial   = {rem_ff, dvd_ff[NUM_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W) + CNT_W'(shift);
         dvd_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, zeros once the numerator is used up
         dvd_in = {dvd_ff[NUM_W-2:0], 1'b0};
         ovf_in = ovf_ff | quo_ff[QUO_W-1];
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign ovf  = ovf_ff;
endmodule

/* sv/bme_sqrt.sv */
// Serial integer square root, one root bit per cycle.
// Depends on bme_pkg.
module bme_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [2*bme_pkg::ROOT_W-1:0] x,
   output logic                        done,
   output logic [bme_pkg::ROOT_W-1:0]  root
);
   import bme_pkg::*;

   localparam int RCNT_W = $clog2(ROOT_W + 1);
   localparam int REM_W  = ROOT_W + 2;

   logic                busy_ff, busy_in, done_ff, done_in;
   logic [RCNT_W-1:0]   cnt_ff, cnt_in;
   logic [2*ROOT_W-1:0] x_ff, x_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [REM_W+1:0]    part, trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      part    = {rem_ff, x_ff[2*ROOT_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = RCNT_W'(ROOT_W);
         x_in    = x;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         // bring down two bits, try appending a one to the root
         x_in = {x_ff[2*ROOT_W-3:0], 2'b00};
         if (part >= trial) begin
            rem_in  = REM_W'(part - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = part[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == RCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

/* sv/bme_ctrl.sv */
// Sequencer for the estimator: accepts words and steps the end-of-run math.
// Depends on bme_pkg.
module bme_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  bme_pkg::status_type status,
   output bme_pkg::cmd_type    cmd
);
   import bme_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.op        = OP_NONE;
      cmd.req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // hold off a run-ending word while the last result is still unread
            cmd.req_ready = !(status.rsp_busy && status.last_item);
            if (req_valid && cmd.req_ready && status.last_item) begin
               state_in = ST_BS;
            end
         end
         ST_BS:   begin cmd.op = OP_BS;   state_in = ST_TT;   end
         ST_TT:   begin cmd.op = OP_TT;   state_in = ST_QLO;  end
         ST_QLO:  begin cmd.op = OP_QLO;  state_in = ST_QHI;  end
         ST_QHI:  begin cmd.op = OP_QHI;  state_in = ST_BB1;  end
         ST_BB1:  begin cmd.op = OP_BB1;  state_in = ST_SS;   end
         ST_SS:   begin cmd.op = OP_SS;   state_in = ST_DEN;  end
         ST_DEN:  begin cmd.op = OP_DEN;  state_in = ST_D2LO; end
         ST_D2LO: begin cmd.op = OP_D2LO; state_in = ST_D2HI; end
         ST_D2HI: begin cmd.op = OP_D2HI; state_in = ST_NUM;  end
         ST_NUM:  begin cmd.op = OP_NUM;  state_in = ST_MEAN_GO; end
         ST_MEAN_GO: begin
            cmd.op   = OP_MEAN_START;
            state_in = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_MEAN_STORE;
               state_in = status.b_is_one ? ST_OUT : ST_VAR_GO;
            end
         end
         ST_VAR_GO: begin
            cmd.op   = OP_VAR_START;
            state_in = ST_VAR_WAIT;
         end
         ST_VAR_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_VAR_STORE;
               state_in = ST_SE_GO;
            end
         end
         ST_SE_GO: begin
            cmd.op   = OP_SE_START;
            state_in = ST_SE_WAIT;
         end
         ST_SE_WAIT: begin
            if (status.div_done) begin
               cmd.op   = OP_SE_STORE;
               state_in = ST_SQ_GO;
            end
         end
         ST_SQ_GO: begin
            cmd.op   = OP_SQRT_START;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (status.sqrt_done) begin
               cmd.op   = OP_SQRT_STORE;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            cmd.op   = OP_OUT;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

/* sv/bme_dpath.sv */
// Datapath: accumulators, config registers, shared multiplier, divider, root.
// Depends on bme_pkg, bme_div and bme_sqrt.
module bme_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [bme_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                            req_valid,
   input  logic [bme_pkg::SAMPLE_W-1:0]    req_sample,
   input  bme_pkg::cmd_type                cmd,
   output bme_pkg::status_type             status,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [31:0]                     rsp_run_total,
   output logic [51:0]                     rsp_run_sum_squares,
   output logic [23:0]                     rsp_mean_q16,
   output logic [30:0]                     rsp_variance_q16,
   output logic [23:0]                     rsp_std_error_q16
);
   import bme_pkg::*;

   localparam logic [QUO_W-1:0] CAP24 = QUO_W'((64'd1 << 24) - 1);
   localparam logic [QUO_W-1:0] CAP31 = QUO_W'((64'd1 << 31) - 1);
   localparam logic [QUO_W-1:0] CAP48 = QUO_W'((64'd1 << 48) - 1);

   logic [CSR_W-1:0] size_ff, count_ff, samples_ff, blocks_ff;
   logic [19:0]      block_sum_ff;
   logic [31:0]      run_sum_ff;
   logic [51:0]      run_sq_ff;
   logic             accept;
   logic [19:0]      bsum_new;
   logic [31:0]      rsum_new;
   logic [51:0]      rsq_new;

   // snapshot and intermediate terms
   logic [EFF_W-1:0] b_ff, s_ff;
   logic [31:0]      t_ff;
   logic [51:0]      q_ff;
   logic [24:0]      bs_ff, ss_ff;
   logic [23:0]      bb1_ff;
   logic [63:0]      tt_ff, sq_ff, num_ff;
   logic [47:0]      den_ff;
   logic [DEN_W-1:0] den2_ff;
   logic [47:0]      x_ff;
   logic [23:0]      mean_ff, se_ff;
   logic [30:0]      var_ff;
   logic             rsp_valid_ff;

   logic [31:0]      mul_a, mul_b;
   logic [63:0]      mul_p;

   logic             div_start, div_done, div_ovf;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic [SHIFT_W-1:0] div_shift;
   logic [QUO_W-1:0] div_quo;
   logic             sqrt_done;
   logic [ROOT_W-1:0] sqrt_root;

   assign accept   = req_valid && cmd.req_ready;
   assign bsum_new = block_sum_ff + 20'(req_sample);
   assign rsum_new = run_sum_ff + 32'(bsum_new);
   assign rsq_new  = run_sq_ff + 52'(40'(bsum_new) * 40'(bsum_new));

   // config and accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= CSR_W'(1000);
         count_ff     <= CSR_W'(100);
         samples_ff   <= CSR_W'(1000);
         blocks_ff    <= CSR_W'(100);
         block_sum_ff <= '0;
         run_sum_ff   <= '0;
         run_sq_ff    <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_BLOCK_SIZE) begin
            size_ff    <= csr_wdata;
            samples_ff <= csr_wdata;
         end else begin
            count_ff  <= csr_wdata;
            blocks_ff <= csr_wdata;
         end
      end else if (accept) begin
         if (samples_ff == CSR_W'(1)) begin
            samples_ff   <= size_ff;
            block_sum_ff <= '0;
            if (blocks_ff == CSR_W'(1)) begin
               blocks_ff  <= count_ff;
               run_sum_ff <= '0;
               run_sq_ff  <= '0;
            end else begin
               blocks_ff  <= blocks_ff - 1'b1;
               run_sum_ff <= rsum_new;
               run_sq_ff  <= rsq_new;
            end
         end else begin
            samples_ff   <= samples_ff - 1'b1;
            block_sum_ff <= bsum_new;
         end
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_BS:   begin mul_a = 32'(b_ff);   mul_b = 32'(s_ff); end
         OP_TT:   begin mul_a = t_ff;        mul_b = t_ff; end
         OP_QLO:  begin mul_a = 32'(b_ff);   mul_b = q_ff[31:0]; end
         OP_QHI:  begin mul_a = 32'(b_ff);   mul_b = 32'(q_ff[51:32]); end
         OP_BB1:  begin mul_a = 32'(b_ff);   mul_b = 32'(b_ff - 1'b1); end
         OP_SS:   begin mul_a = 32'(s_ff);   mul_b = 32'(s_ff); end
         OP_DEN:  begin mul_a = 32'(bb1_ff); mul_b = 32'(ss_ff); end
         OP_D2LO: begin mul_a = 32'(b_ff);   mul_b = den_ff[31:0]; end
         OP_D2HI: begin mul_a = 32'(b_ff);   mul_b = 32'(den_ff[47:32]); end
         default: begin mul_a = '0;          mul_b = '0; end
      endcase
   end
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_num   = num_ff;
      div_den   = DEN_W'(den_ff);
      div_shift = SHIFT_W'(FRACTION_BITS);
      case (cmd.op)
         OP_MEAN_START: begin
            div_start = 1'b1;
            div_num   = NUM_W'(t_ff);
            div_den   = DEN_W'(bs_ff);
         end
         OP_VAR_START: begin
            div_start = 1'b1;
         end
         OP_SE_START: begin
            div_start = 1'b1;
            div_den   = den2_ff;
            div_shift = SHIFT_W'(2 * FRACTION_BITS);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && samples_ff == CSR_W'(1) && blocks_ff == CSR_W'(1)) begin
         // snapshot the finished run, zero count means 4096
         t_ff <= rsum_new;
         q_ff <= rsq_new;
         b_ff <= {count_ff == '0, count_ff};
         s_ff <= {size_ff == '0, size_ff};
      end
      case (cmd.op)
         OP_BS:   bs_ff   <= mul_p[24:0];
         OP_TT:   tt_ff   <= mul_p;
         OP_QLO:  sq_ff   <= mul_p;
         OP_QHI:  sq_ff   <= sq_ff + {mul_p[31:0], 32'd0};
         OP_BB1:  bb1_ff  <= mul_p[23:0];
         OP_SS:   ss_ff   <= mul_p[24:0];
         OP_DEN:  den_ff  <= mul_p[47:0];
         OP_D2LO: den2_ff <= mul_p[DEN_W-1:0];
         OP_D2HI: den2_ff <= den2_ff + {mul_p[DEN_W-33:0], 32'd0};
         OP_NUM:  num_ff  <= (sq_ff > tt_ff) ? sq_ff - tt_ff : 64'd0;
         OP_MEAN_STORE: begin
            mean_ff <= (div_ovf || div_quo > CAP24) ? 24'hFF_FFFF : div_quo[23:0];
            var_ff  <= '0;
            se_ff   <= '0;
         end
         OP_VAR_STORE:
            var_ff <= (div_ovf || div_quo > CAP31) ? 31'h7FFF_FFFF : div_quo[30:0];
         OP_SE_STORE:
            x_ff <= (div_ovf || div_quo > CAP48) ? 48'hFFFF_FFFF_FFFF : div_quo[47:0];
         OP_SQRT_STORE:
            se_ff <= sqrt_root;
         OP_OUT: begin
            rsp_run_total       <= t_ff;
            rsp_run_sum_squares <= q_ff;
            rsp_mean_q16        <= mean_ff;
            rsp_variance_q16    <= var_ff;
            rsp_std_error_q16   <= se_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_OUT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   bme_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .shift (div_shift),
      .done  (div_done),
      .quo   (div_quo),
      .ovf   (div_ovf)
   );

   bme_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.op == OP_SQRT_START),
      .x     (x_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign status.last_item = (samples_ff == CSR_W'(1)) && (blocks_ff == CSR_W'(1));
   assign status.rsp_busy  = rsp_valid_ff;
   assign status.div_done  = div_done;
   assign status.sqrt_done = sqrt_done;
   assign status.b_is_one  = (b_ff == EFF_W'(1));
endmodule

/* sv/bme_checker.sv */
// Port-level checks for the estimator top level, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bme_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_run_total,
   input logic [23:0] rsp_mean_q16
);
   `BME_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BME_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_run_total) && $stable(rsp_mean_q16))
   `BME_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid)
   `BME_ASSERT_NOW(a_result_after_stall, clock, reset, $rose(rsp_valid), !$past(req_ready))
endmodule

bind batch_means_error_estimator_core bme_checker u_bme_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_word.ready),
   .rsp_valid     (rsp_word.valid),
   .rsp_ready     (rsp_word.ready),
   .rsp_run_total (rsp_word.run_total),
   .rsp_mean_q16  (rsp_word.mean_q16)
);

/* tb/bme_stats_checker.sv */
// Scoreboard for the batch-means error estimator: predicts each statistics word.
// Depends on bme_pkg and bme_if; instantiated by batch_means_error_estimator_core_test.
module bme_stats_checker
   import bme_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   bme_req_if               req_mon,
   bme_rsp_if               rsp_mon,
   output int               mismatch_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit [31:0] total;
      bit [51:0] sum_sq;
      bit [23:0] mean;
      bit [30:0] variance;
      bit [23:0] std_err;
   } stats_word_type;

   stats_word_type expected_stats[$];

   bit [11:0] size_reg, count_reg, samples_left, blocks_left;
   bit [19:0] block_sum;
   bit [31:0] run_sum;
   bit [51:0] run_sq_sum;

   // floor(num * 2^shift / den), clamped to the all-ones value of width bits
   function automatic bit [63:0] scaled_quotient(bit [63:0] num, bit [63:0] den,
                                                 int shift, int width);
      bit [63:0] cap, q, r;
      cap = (64'd1 << width) - 64'd1;
      q = num / den;
      r = num % den;
      if (q > cap) return cap;
      for (int i = 0; i < shift; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
         if (q > cap) return cap;
      end
      return q;
   endfunction

   function automatic bit [63:0] root_floor(bit [63:0] x);
      bit [63:0] res, bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // A zero register means a full 4096-long countdown
   function automatic bit [63:0] span(bit [11:0] v);
      return (v == 0) ? 64'd4096 : {52'd0, v};
   endfunction

   task automatic take_sample(bit [7:0] smp);
      bit [63:0] s, b, t, q, sq, tt, num, den, root;
      stats_word_type w;
      block_sum = block_sum + 20'(smp);
      samples_left = samples_left - 12'd1;
      if (samples_left != 0) return;
      run_sum = run_sum + 32'(block_sum);
      run_sq_sum = run_sq_sum + 52'(64'(block_sum) * 64'(block_sum));
      samples_left = size_reg;
      block_sum = '0;
      blocks_left = blocks_left - 12'd1;
      if (blocks_left != 0) return;
      s = span(size_reg);
      b = span(count_reg);
      t = 64'(run_sum);
      q = 64'(run_sq_sum);
      w.total = run_sum;
      w.sum_sq = run_sq_sum;
      w.mean = 24'(scaled_quotient(t, b * s, FRACTION_BITS, 24));
      sq = b * q;
      tt = t * t;
      // mid-run writes can push the numerator below zero: clamp it
      num = (sq > tt) ? sq - tt : 64'd0;
      if (b < 2) begin
         w.variance = '0;
         w.std_err = '0;
      end else begin
         den = b * (b - 64'd1) * s * s;
         w.variance = 31'(scaled_quotient(num, den, FRACTION_BITS, 31));
         root = root_floor(scaled_quotient(num, b * den, 2 * FRACTION_BITS, 48));
         w.std_err = (root > 64'hFFFFFF) ? 24'hFFFFFF : 24'(root);
      end
      expected_stats.push_back(w);
      run_sum = '0;
      run_sq_sum = '0;
      blocks_left = count_reg;
   endtask

   task automatic flag(string what, bit [63:0] exp_v, bit [63:0] act_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
   endtask

   always @(posedge clock) begin
      stats_word_type w;
      if (reset) begin
         size_reg = 12'd1000;
         count_reg = 12'd100;
         samples_left = 12'd1000;
         blocks_left = 12'd100;
         block_sum = '0;
         run_sum = '0;
         run_sq_sum = '0;
         expected_stats.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_BLOCK_SIZE) begin
               size_reg = csr_wdata;
               samples_left = csr_wdata;
            end else begin
               count_reg = csr_wdata;
               blocks_left = csr_wdata;
            end
         end
         if (req_mon.valid && req_mon.ready) take_sample(req_mon.sample);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_stats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: statistics word with none expected", $time);
            end else begin
               w = expected_stats.pop_front();
               if (rsp_mon.run_total !== w.total)
                  flag("run_total", w.total, rsp_mon.run_total);
               if (rsp_mon.run_sum_squares !== w.sum_sq)
                  flag("run_sum_squares", w.sum_sq, rsp_mon.run_sum_squares);
               if (rsp_mon.mean_q16 !== w.mean)
                  flag("mean_q16", w.mean, rsp_mon.mean_q16);
               if (rsp_mon.variance_q16 !== w.variance)
                  flag("variance_q16", w.variance, rsp_mon.variance_q16);
               if (rsp_mon.std_error_q16 !== w.std_err)
                  flag("std_error_q16", w.std_err, rsp_mon.std_error_q16);
            end
         end
      end
      pending_count <= expected_stats.size();
   end
endmodule

/* tb/batch_means_error_estimator_core_test.sv */
// Top of the estimator testbench: clock, reset, sample stimulus and verdict.
// Depends on bme_pkg, bme_if, the core RTL and bme_stats_checker.
module batch_means_error_estimator_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bme_pkg::*;

   // Settling wait, comfortably longer than the end-of-run statistics
   localparam int SETTLE_CYCLES = 600;
   localparam int CYCLE_LIMIT   = 3000000;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;
   int               mismatch_count;
   int               pending_count;
   int               cycle_count;
   bit               quiet;
   bit               hold_req;

   bme_req_if req_word ();
   bme_rsp_if rsp_word ();

   batch_means_error_estimator_core dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .rsp_word  (rsp_word)
   );

   bme_stats_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_mon        (req_word),
      .rsp_mon        (rsp_word),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off once asked for while
   // run-ending words keep coming, so the output register stays full and the
   // block backs up its input
   initial begin
      bit held;
      held = 0;
      rsp_word.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && hold_req) begin
            held = 1;
            rsp_word.ready = 1'b0;
            for (int i = 0; i < 3000; i++) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_word.ready = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end else begin
            rsp_word.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic csr_write(csr_index_type idx, bit [CSR_W-1:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Offer one sample word, optionally after an idle burst, and hold until taken
   task automatic send_word(bit [7:0] smp);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_word.valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_word.valid = 1'b1;
      req_word.sample = smp;
      @(posedge clock);
      while (!req_word.ready) @(posedge clock);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_word.valid = 1'b0;
   endtask

   // Bit-error style 0/1 samples half the time, with full-range bytes and extremes mixed in
   function automatic bit [7:0] error_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 8'($urandom_range(0, 1));
         8:             return 8'hFF;
         9:             return 8'h00;
         default:       return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Drain outstanding statistics, then let a possibly busy block settle
   task automatic drain();
      stop_sending();
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(bit [11:0] size, bit [11:0] count, int n_words);
      csr_write(CSR_BLOCK_SIZE, size);
      csr_write(CSR_BLOCK_COUNT, count);
      for (int i = 0; i < n_words; i++) send_word(error_sample());
      drain();
   endtask

   task automatic send_fill(bit [7:0] smp, int n_words);
      for (int i = 0; i < n_words; i++) send_word(smp);
   endtask

   initial begin
      int n;
      quiet = 0;
      hold_req = 0;
      cycle_count = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_BLOCK_SIZE;
      csr_wdata = '0;
      req_word.valid = 1'b0;
      req_word.sample = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: smallest runs with extreme bytes
      csr_write(CSR_BLOCK_SIZE, 12'd1);
      csr_write(CSR_BLOCK_COUNT, 12'd2);
      send_word(8'h00); send_word(8'hFF);
      send_word(8'hFF); send_word(8'hFF);
      send_word(8'h00); send_word(8'h00);
      drain();
      // One block per run: spread figures are forced to zero
      csr_write(CSR_BLOCK_COUNT, 12'd1);
      send_word(8'hFF); send_word(8'h00); send_word(8'h5A);
      drain();
      csr_write(CSR_BLOCK_SIZE, 12'd3);
      csr_write(CSR_BLOCK_COUNT, 12'd3);
      send_word(8'h01); send_word(8'h80); send_word(8'h7F);
      send_word(8'hAA); send_word(8'h55); send_word(8'h01);
      send_word(8'h00); send_word(8'hFE); send_word(8'h01);
      drain();

      // Back-pressure: hold off the result side while run-ending words keep coming
      csr_write(CSR_BLOCK_SIZE, 12'd1);
      csr_write(CSR_BLOCK_COUNT, 12'd2);
      hold_req = 1;
      for (int i = 0; i < 20; i++) send_word(error_sample());
      drain();

      // Large subtotals with full-scale bytes
      csr_write(CSR_BLOCK_SIZE, 12'd200);
      csr_write(CSR_BLOCK_COUNT, 12'd2);
      send_fill(8'hFF, 400);
      drain();

      // Random phases with small sizes; phase lengths leave runs half done
      n = 0;
      while (n < 1510) begin
         int len;
         len = $urandom_range(20, 150);
         if (n > 1260) quiet = 1;
         if ($urandom_range(0, 9) == 0)
            run_phase(12'($urandom_range(1, 40)), 12'($urandom_range(1, 4)), len);
         else
            run_phase(12'($urandom_range(1, 6)), 12'($urandom_range(1, 6)), len);
         n += len;
      end

      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+sv
sv/bme_pkg.sv
sv/bme_if.sv
sv/bme_div.sv
sv/bme_sqrt.sv
sv/bme_ctrl.sv
sv/bme_dpath.sv
sv/batch_means_error_estimator_core.sv
sv/bme_checker.sv
tb/bme_stats_checker.sv
tb/batch_means_error_estimator_core_test.sv
